[rtl/core/chessboard_distance_raster_pass_macros.svh]
// assertion macros for the chessboard distance raster pass
`ifndef CHESSBOARD_DISTANCE_RASTER_PASS_MACROS_SVH
`define CHESSBOARD_DISTANCE_RASTER_PASS_MACROS_SVH

// same-cycle implication, checked on the rising edge of clk outside reset
`define CDRP_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on the rising edge of clk outside reset
`define CDRP_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cdrp_pkg.sv]
// shared types and constants of the chessboard distance raster pass
package cdrp_pkg;

  // field and register widths
  localparam int ROW_WIDTH_W = 12;
  localparam int LIMIT_W     = 16;
  localparam int DISTANCE_W  = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_WIDTH      = 1'b0,
    REG_DISTANCE_LIMIT = 1'b1
  } cfg_reg_t;

  // register reset values
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 12'd2048;
  localparam logic [LIMIT_W-1:0]     LIMIT_RESET     = 16'd0;

endpackage

[rtl/core/cdrp_pixel_if.sv]
// pixel input channel: valid/ready with pixel and image start flag
interface cdrp_pixel_if;
  logic valid;
  logic ready;
  logic pixel;
  logic start_of_image;

  modport source (output valid, output pixel, output start_of_image, input ready);
  modport sink   (input valid, input pixel, input start_of_image, output ready);
endinterface

[rtl/core/cdrp_dist_if.sv]
// distance output channel: valid/ready with distance and row end flag
interface cdrp_dist_if;
  import cdrp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DISTANCE_W-1:0] distance;
  logic                  row_end;

  modport source (output valid, output distance, output row_end, input ready);
  modport sink   (input valid, input distance, input row_end, output ready);
endinterface

[rtl/core/chessboard_distance_raster_pass.sv]
// top level of the chessboard distance raster pass
//
// Binary pixels enter in raster order on the pixels channel, one transfer per
// pixel; start_of_image on the first pixel of an image clears all row history.
// Each pixel gives one transfer on the distances channel, carrying its
// translated D8 distance and a flag on the last pixel of its row.
// Configuration (row width, distance limit) goes through the write port while
// the block is idle.
// Throughput: one pixel per cycle unless the receiver stalls. A single simple
// dual-port memory holds both previous rows, one entry per column; it is read
// once per accepted pixel and written once per finished pixel, with a bypass
// when the two hit the same column. A fill count marks the columns written
// since image start, so no clearing pass is needed at reset or image start.
// A pixel passes the memory read stage, then the output register, on its way
// to the distances channel. Reset empties both stages and restores row width
// 2048 and limit 0 (full scale). When the receiver stalls, the output register
// holds its transfer; one more pixel may be accepted into the read stage, then
// ready falls.
`include "chessboard_distance_raster_pass_macros.svh"

module chessboard_distance_raster_pass #(
  parameter int MAX_COLS   = 2048,
  parameter int DIST_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [cdrp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cdrp_pkg::CFG_DATA_W-1:0]  cfg_data,
  cdrp_pixel_if.sink                     pixels,
  cdrp_dist_if.source                    distances
);
  import cdrp_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int MEM_W = 2 * DIST_WIDTH;
  localparam logic [63:0] FULL_SCALE = (64'd1 << DIST_WIDTH) - 64'd1;

  // configuration registers
  logic [ROW_WIDTH_W-1:0] row_width;
  logic [LIMIT_W-1:0]     distance_limit;

  // input side state
  logic [COL_W-1:0] column_index;
  logic [CNT_W-1:0] fill;

  // row memory: upper half two rows above, lower half one row above
  logic [MEM_W-1:0] mem [MAX_COLS];
  logic [MEM_W-1:0] mem_q;
  logic [MEM_W-1:0] fwd_q;

  // read stage
  logic             s1_valid;
  logic             s1_pixel;
  logic             s1_first;
  logic             s1_last;
  logic             s1_fwd;
  logic             s1_rdv;
  logic [COL_W-1:0] s1_col;

  // neighbour window and left results
  logic [DIST_WIDTH-1:0] a1, a2, b1, b2, left_one, left_two;

  // output register
  logic                  out_valid;
  logic [DISTANCE_W-1:0] out_distance;
  logic                  out_row_end;

  logic                  accept;
  logic                  s1_move;
  logic [COL_W-1:0]      col_a;
  logic [CNT_W-1:0]      col_inc;
  logic [CNT_W-1:0]      used_width;
  logic                  row_last;
  logic                  rdv_a;
  logic                  fwd_a;
  logic [DIST_WIDTH-1:0] cap;
  logic [MEM_W-1:0]      rd_word;
  logic [DIST_WIDTH-1:0] up0, up2_0;
  logic [DIST_WIDTH-1:0] e_a1, e_a2, e_b1, e_b2, e_l1, e_l2;
  logic [DIST_WIDTH-1:0] m1, m2, m3, m4, m5, m6, m7, m_all;
  logic [DIST_WIDTH-1:0] val;
  logic [MEM_W-1:0]      wr_data;

  function automatic logic [DIST_WIDTH-1:0] min2(input logic [DIST_WIDTH-1:0] x,
                                                input logic [DIST_WIDTH-1:0] y);
    return (x < y) ? x : y;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width      <= ROW_WIDTH_RESET;
      distance_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_WIDTH:      row_width      <= cfg_data[ROW_WIDTH_W-1:0];
        REG_DISTANCE_LIMIT: distance_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective row width, zero means one, saturated to the memory depth
  always_comb begin
    if (row_width == '0) begin
      used_width = CNT_W'(1);
    end else if (int'(row_width) > MAX_COLS) begin
      used_width = CNT_W'(MAX_COLS);
    end else begin
      used_width = CNT_W'(row_width);
    end
  end

  // minimum ceiling before the increment: limit minus one, zero gives full scale
  always_comb begin
    if (distance_limit == '0 || 64'(distance_limit) > FULL_SCALE) begin
      cap = DIST_WIDTH'(FULL_SCALE - 64'd1);
    end else begin
      cap = DIST_WIDTH'(distance_limit) - DIST_WIDTH'(1);
    end
  end

  // handshake
  assign s1_move      = s1_valid && (!out_valid || distances.ready);
  assign pixels.ready = !s1_valid || s1_move;
  assign accept       = pixels.valid && pixels.ready;

  // column tracking and read qualification on the input side
  assign col_a    = pixels.start_of_image ? '0 : column_index;
  assign col_inc  = CNT_W'(col_a) + CNT_W'(1);
  assign row_last = (col_inc >= used_width);
  assign rdv_a    = !pixels.start_of_image && (CNT_W'(col_a) < fill);
  assign fwd_a    = !pixels.start_of_image && s1_move && (s1_col == col_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
    end else if (accept) begin
      column_index <= row_last ? '0 : COL_W'(col_inc);
    end
  end

  // fill count: columns written since image start
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept && pixels.start_of_image) begin
      fill <= '0;
    end else if (s1_move && CNT_W'(s1_col) >= fill) begin
      fill <= CNT_W'(s1_col) + CNT_W'(1);
    end
  end

  // row memory, read on transfer in, written when a result leaves the read stage
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q <= mem[col_a];
      fwd_q <= wr_data;
    end
    if (s1_move) begin
      mem[s1_col] <= wr_data;
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixels.ready) begin
      s1_valid <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixels.pixel;
      s1_first <= (col_a == '0);
      s1_last  <= row_last;
      s1_fwd   <= fwd_a;
      s1_rdv   <= rdv_a;
      s1_col   <= col_a;
    end
  end

  // neighbours, zero outside the image or before the row start
  assign rd_word = s1_fwd ? fwd_q : (s1_rdv ? mem_q : '0);
  assign up0     = rd_word[DIST_WIDTH-1:0];
  assign up2_0   = rd_word[MEM_W-1:DIST_WIDTH];
  assign e_a1    = s1_first ? '0 : a1;
  assign e_a2    = s1_first ? '0 : a2;
  assign e_b1    = s1_first ? '0 : b1;
  assign e_b2    = s1_first ? '0 : b2;
  assign e_l1    = s1_first ? '0 : left_one;
  assign e_l2    = s1_first ? '0 : left_two;

  // eight-way minimum tree, capped
  assign m1    = min2(e_l1, e_l2);
  assign m2    = min2(up0, e_a1);
  assign m3    = min2(e_a2, up2_0);
  assign m4    = min2(e_b1, e_b2);
  assign m5    = min2(m1, m2);
  assign m6    = min2(m3, m4);
  assign m7    = min2(m5, m6);
  assign m_all = min2(m7, cap);

  assign val     = s1_pixel ? (m_all + DIST_WIDTH'(1)) : '0;
  assign wr_data = {up0, val};

  // shift the window as a pixel leaves the read stage
  always_ff @(posedge clk) begin
    if (s1_move) begin
      a1       <= up0;
      a2       <= e_a1;
      b1       <= up2_0;
      b2       <= e_b1;
      left_one <= val;
      left_two <= e_l1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (distances.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_distance <= DISTANCE_W'(val);
      out_row_end  <= s1_last;
    end
  end

  assign distances.valid    = out_valid;
  assign distances.distance = out_distance;
  assign distances.row_end  = out_row_end;

  // checks
  `CDRP_CHECK(a_ready_stall, !pixels.ready, s1_valid && out_valid && !distances.ready, "ready low without a stalled output")
  `CDRP_CHECK_NEXT(a_move_fills_out, s1_move, out_valid, "result left the read stage but output is empty")
  `CDRP_CHECK_NEXT(a_image_start_clears, accept && pixels.start_of_image, fill == '0, "fill count not cleared at image start")
  `CDRP_CHECK(a_read_within_fill, s1_valid && s1_rdv, CNT_W'(s1_col) < fill, "qualified read beyond written columns")

endmodule
